// ===== rtl/ctsc_pkg.sv =====
// Shared types and constants for the clock time-setting controller.
`default_nettype none

package ctsc_pkg;

    localparam int CNT_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;

    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    localparam logic [CNT_W-1:0] LONG_PRESS_RST   = 16'd3000;
    localparam logic [CNT_W-1:0] IDLE_TIMEOUT_RST = 16'd8000;
    localparam logic [CNT_W-1:0] BLINK_PERIOD_RST = 16'd1000;
    localparam logic [CNT_W-1:0] BLINK_SHOW_RST   = 16'd500;

    localparam logic [6:0] MINUTES_PER_HOUR = 7'd60;
    localparam logic [5:0] HOURS_PER_DAY    = 6'd24;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_SHOW   = 2'd3;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_SEC    = 2'd1,
        MODE_MIN    = 2'd2,
        MODE_HOUR   = 2'd3
    } mode_t;

    typedef struct packed {
        logic [CNT_W-1:0] long_press_ticks;
        logic [CNT_W-1:0] idle_timeout_ticks;
        logic [CNT_W-1:0] blink_period_ticks;
        logic [CNT_W-1:0] blink_show_after;
    } cfg_t;

    // the first declared field lands in the high bits, the last in the low bits
    typedef struct packed {
        logic [5:0] rtc_second;
        logic [5:0] rtc_minute;
        logic [4:0] rtc_hour;
        logic       front_pressed;
        logic       back_pressed;
    } in_item_t;

    typedef struct packed {
        logic [5:0] new_second;
        logic [5:0] new_minute;
        logic [4:0] new_hour;
        logic       rtc_write;
        logic       led_level;
        logic       blank_selected;
        logic [5:0] show_second;
        logic [5:0] show_minute;
        logic [4:0] show_hour;
        mode_t      clock_mode;
    } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/clock_time_setting_controller_core.sv =====
// Top level of the clock time-setting controller: stream ports and pipeline registers.
//
// One beat on the s_ channel per millisecond tick: the back/front button levels and the
// time read from the clock chip. Each input beat yields exactly one m_ beat carrying the
// mode, the display values, the blank flag, the LED level and an optional time-write
// request for the clock chip.
// Pipeline: input register, one pass of update logic, output register. An accepted beat
// passes from the input register through the update logic into the output register,
// where m_tvalid marks it; throughput is one beat per cycle while m_tready stays high.
// When the receiver drops m_tready, the finished beat waits in the output register and
// one further beat is still taken into the input register; after that s_tready falls
// until the output drains. State updates happen only as a beat moves to the output.
// Reset (aresetn low, synchronous) clears both pipeline stages, puts the block in normal
// mode with the LED level high and a zero display, and loads the default config values.
// The cfg_ port writes one of four 16-bit registers per cycle while cfg_wr_en is high;
// write it only while no beat is in flight.
`default_nettype none

module clock_time_setting_controller_core
    import ctsc_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // back_pressed, front_pressed, rtc_hour[4:0], rtc_minute[5:0], rtc_second[5:0]
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // clock_mode[1:0], show_hour[4:0], show_minute[5:0], show_second[5:0],
    // blank_selected, led_level, rtc_write, new_hour[4:0], new_minute[5:0], new_second[5:0]
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CNT_W-1:0]       cfg_wdata
);

    localparam int IN_ITEM_W  = $bits(in_item_t);
    localparam int OUT_ITEM_W = $bits(out_item_t);

    cfg_t      cfg;
    out_item_t result;

    logic      in_valid_reg, in_valid_next;
    in_item_t  in_item_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg;
    logic      s_fire;
    logic      advance;

    ctsc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ctsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .cfg     (cfg),
        .item    (in_item_reg),
        .result  (result)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next  = s_fire || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg <= in_item_t'(s_tdata[IN_ITEM_W-1:0]);
        end
        if (advance) begin
            out_item_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-OUT_ITEM_W){1'b0}}, out_item_reg};

    // time writes come only from a setting mode
    a_write_in_setting: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_item_reg.rtc_write |-> out_item_reg.clock_mode != MODE_NORMAL)
        else $error("time write issued in normal mode");

    // write fields read zero when no write is requested
    a_write_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !out_item_reg.rtc_write |->
            out_item_reg.new_hour == '0 && out_item_reg.new_minute == '0 &&
            out_item_reg.new_second == '0)
        else $error("write fields nonzero without a write");

    // an input beat held back from the update stage keeps s_tready low
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_tready |-> !s_tready)
        else $error("input accepted while both stages are full");

endmodule

`default_nettype wire

// ===== rtl/ctsc_cfg.sv =====
// Configuration registers of the time-setting controller.
`default_nettype none

module ctsc_cfg
    import ctsc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CNT_W-1:0]     cfg_wdata,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LONG_PRESS:   cfg_next.long_press_ticks   = cfg_wdata;
                CFG_IDLE_TIMEOUT: cfg_next.idle_timeout_ticks = cfg_wdata;
                CFG_BLINK_PERIOD: cfg_next.blink_period_ticks = cfg_wdata;
                CFG_BLINK_SHOW:   cfg_next.blink_show_after   = cfg_wdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_press_ticks   <= LONG_PRESS_RST;
            cfg_reg.idle_timeout_ticks <= IDLE_TIMEOUT_RST;
            cfg_reg.blink_period_ticks <= BLINK_PERIOD_RST;
            cfg_reg.blink_show_after   <= BLINK_SHOW_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/ctsc_ctrl.sv =====
// Mode, hold, idle and blink state plus the per-tick update logic.
`default_nettype none

module ctsc_ctrl
    import ctsc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     step,
    input  wire cfg_t     cfg,
    input  wire in_item_t item,
    output out_item_t     result
);

    mode_t            mode_reg, mode_next;
    logic             hold_timing_reg, hold_timing_next;
    logic [CNT_W-1:0] hold_count_reg, hold_count_next;
    logic [CNT_W-1:0] idle_count_reg, idle_count_next;
    logic [CNT_W-1:0] blink_phase_reg, blink_phase_next;
    logic             prev_back_reg, prev_back_next;
    logic             prev_front_reg, prev_front_next;
    logic [5:0]       prev_second_reg, prev_second_next;
    logic             led_reg, led_next;
    logic [4:0]       disp_hour_reg, disp_hour_next;
    logic [5:0]       disp_minute_reg, disp_minute_next;
    logic [5:0]       disp_second_reg, disp_second_next;
    mode_t            dark_reg, dark_next;   // MODE_NORMAL = nothing dark

    logic [6:0] minute_sum;
    logic [5:0] minute_inc;
    logic [5:0] hour_sum;
    logic [4:0] hour_inc;

    // (x + 1) mod n with x below 2n - 1: one compare and subtract
    always_comb begin
        minute_sum = {1'b0, item.rtc_minute} + 7'd1;
        if (minute_sum >= MINUTES_PER_HOUR) begin
            minute_sum = minute_sum - MINUTES_PER_HOUR;
        end
        minute_inc = minute_sum[5:0];
        hour_sum = {1'b0, item.rtc_hour} + 6'd1;
        if (hour_sum >= HOURS_PER_DAY) begin
            hour_sum = hour_sum - HOURS_PER_DAY;
        end
        hour_inc = hour_sum[4:0];
    end

    always_comb begin
        logic [CNT_W-1:0] hold_cnt;
        logic [CNT_W:0]   phase_inc;
        mode_t            sel;
        logic             wr;
        logic [4:0]       nh;
        logic [5:0]       nm;
        logic [5:0]       ns;

        mode_next        = mode_reg;
        hold_timing_next = hold_timing_reg;
        hold_count_next  = hold_count_reg;
        idle_count_next  = idle_count_reg;
        blink_phase_next = blink_phase_reg;
        prev_back_next   = prev_back_reg;
        prev_front_next  = prev_front_reg;
        prev_second_next = prev_second_reg;
        led_next         = led_reg;
        disp_hour_next   = disp_hour_reg;
        disp_minute_next = disp_minute_reg;
        disp_second_next = disp_second_reg;
        dark_next        = dark_reg;
        hold_cnt  = hold_count_reg;
        phase_inc = '0;
        sel = MODE_NORMAL;
        wr  = 1'b0;
        nh  = '0;
        nm  = '0;
        ns  = '0;

        // long press of back alone enters set-seconds
        if (mode_reg == MODE_NORMAL) begin
            if (item.back_pressed && !item.front_pressed) begin
                if (!hold_timing_reg) begin
                    hold_timing_next = 1'b1;
                    hold_count_next  = '0;
                end else begin
                    if (hold_count_reg != CNT_MAX) begin
                        hold_cnt = hold_count_reg + 16'd1;
                    end
                    hold_count_next = hold_cnt;
                    if (hold_cnt > cfg.long_press_ticks) begin
                        mode_next        = MODE_SEC;
                        blink_phase_next = '0;
                        prev_back_next   = 1'b1;
                        idle_count_next  = '0;
                        hold_timing_next = 1'b0;
                        hold_count_next  = '0;
                    end
                end
            end else if (!item.back_pressed && hold_timing_reg) begin
                hold_timing_next = 1'b0;
                hold_count_next  = '0;
            end
        end

        if (mode_next != MODE_NORMAL) begin
            if (item.back_pressed && !prev_back_next) begin
                idle_count_next  = '0;
                mode_next        = (mode_next == MODE_HOUR) ? MODE_SEC
                                                            : mode_t'(mode_next + 2'd1);
                blink_phase_next = '0;
            end
            prev_back_next = item.back_pressed;
            sel = mode_next;

            // blink: show the selected unit late in the cycle, dark early
            if (blink_phase_next > cfg.blink_show_after) begin
                case (sel)
                    MODE_SEC: disp_second_next = item.rtc_second;
                    MODE_MIN: disp_minute_next = item.rtc_minute;
                    default:  disp_hour_next   = item.rtc_hour;
                endcase
                if (dark_next == sel) begin
                    dark_next = MODE_NORMAL;
                end
            end else begin
                disp_hour_next   = item.rtc_hour;
                disp_minute_next = item.rtc_minute;
                disp_second_next = item.rtc_second;
                case (sel)
                    MODE_SEC: disp_second_next = '0;
                    MODE_MIN: disp_minute_next = '0;
                    default:  disp_hour_next   = '0;
                endcase
                dark_next = sel;
            end

            if (item.front_pressed && !prev_front_reg) begin
                idle_count_next = '0;
                wr = 1'b1;
                nh = item.rtc_hour;
                nm = item.rtc_minute;
                ns = item.rtc_second;
                case (sel)
                    MODE_SEC: begin
                        ns = '0;
                        disp_second_next = '0;
                    end
                    MODE_MIN: begin
                        nm = minute_inc;
                        disp_minute_next = minute_inc;
                    end
                    default: begin
                        nh = hour_inc;
                        disp_hour_next = hour_inc;
                    end
                endcase
                if (dark_next == sel) begin
                    dark_next = MODE_NORMAL;
                end
            end else if (idle_count_next > cfg.idle_timeout_ticks) begin
                idle_count_next = '0;
                mode_next       = MODE_NORMAL;
            end
            prev_front_next = item.front_pressed;

            if (idle_count_next != CNT_MAX) begin
                idle_count_next = idle_count_next + 16'd1;
            end
            phase_inc = {1'b0, blink_phase_next} + 17'd1;
            if (phase_inc >= {1'b0, cfg.blink_period_ticks}) begin
                blink_phase_next = '0;
            end else begin
                blink_phase_next = phase_inc[CNT_W-1:0];
            end
        end

        // new second: LED toggles; normal mode reloads the display
        if (item.rtc_second != prev_second_reg) begin
            led_next         = !led_reg;
            prev_second_next = item.rtc_second;
            if (mode_next == MODE_NORMAL) begin
                disp_hour_next   = item.rtc_hour;
                disp_minute_next = item.rtc_minute;
                disp_second_next = item.rtc_second;
                dark_next        = MODE_NORMAL;
            end
        end

        result.clock_mode     = mode_next;
        result.show_hour      = disp_hour_next;
        result.show_minute    = disp_minute_next;
        result.show_second    = disp_second_next;
        result.blank_selected = (dark_next != MODE_NORMAL);
        result.led_level      = led_next;
        result.rtc_write      = wr;
        result.new_hour       = nh;
        result.new_minute     = nm;
        result.new_second     = ns;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_NORMAL;
            hold_timing_reg <= 1'b0;
            hold_count_reg  <= '0;
            idle_count_reg  <= '0;
            blink_phase_reg <= '0;
            prev_back_reg   <= 1'b0;
            prev_front_reg  <= 1'b0;
            prev_second_reg <= '0;
            led_reg         <= 1'b1;
            disp_hour_reg   <= '0;
            disp_minute_reg <= '0;
            disp_second_reg <= '0;
            dark_reg        <= MODE_NORMAL;
        end else if (step) begin
            mode_reg        <= mode_next;
            hold_timing_reg <= hold_timing_next;
            hold_count_reg  <= hold_count_next;
            idle_count_reg  <= idle_count_next;
            blink_phase_reg <= blink_phase_next;
            prev_back_reg   <= prev_back_next;
            prev_front_reg  <= prev_front_next;
            prev_second_reg <= prev_second_next;
            led_reg         <= led_next;
            disp_hour_reg   <= disp_hour_next;
            disp_minute_reg <= disp_minute_next;
            disp_second_reg <= disp_second_next;
            dark_reg        <= dark_next;
        end
    end

    // hold timing only runs in normal mode
    a_hold_only_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg != MODE_NORMAL |-> !hold_timing_reg)
        else $error("hold timer running outside normal mode");

    // leaving normal mode always lands in set-seconds
    a_entry_to_sec: assert property (@(posedge aclk) disable iff (!aresetn)
        step && mode_reg == MODE_NORMAL |-> mode_next == MODE_NORMAL || mode_next == MODE_SEC)
        else $error("entry from normal mode skipped set-seconds");

    // a step with no new second leaves the LED alone
    a_led_on_second: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.rtc_second == prev_second_reg |=> $stable(led_reg))
        else $error("LED toggled without a new second");

endmodule

`default_nettype wire
